// File: src/pba_pkg.sv
`timescale 1ns / 1ps

package pba_pkg;

  localparam int BUCKETS_DEF   = 4096;
  localparam int INSTANCES_DEF = 16;

  localparam int CMD_W       = 31;
  localparam int BUCKET_W    = 12;
  localparam int INST_W      = 4;
  localparam int BUCKET_SPAN = 1 << BUCKET_W;

  // tag width of the per-entry clear epoch
  localparam int EPOCH_W   = 8;
  localparam int RED_CNT_W = 4;

  // number of shifted compare-subtract steps that bring start_bucket below buckets
  function automatic int red_steps(input int buckets);
    int n;
    n = 0;
    for (int k = 0; k <= BUCKET_W; k++) begin
      if ((buckets << k) < BUCKET_SPAN) begin
        n++;
      end
    end
    return n;
  endfunction

endpackage

// File: src/pba_in_if.sv
`timescale 1ns / 1ps

interface pba_in_if
  import pba_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                action;
  logic [CMD_W-1:0]    command;
  logic [BUCKET_W-1:0] start_bucket;

  modport source (output valid, action, command, start_bucket, input ready);
  modport sink   (input valid, action, command, start_bucket, output ready);
endinterface

// File: src/pba_out_if.sv
`timescale 1ns / 1ps

interface pba_out_if
  import pba_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;
  logic [INST_W-1:0]   instance_res;
  logic                exhausted;

  modport source (output valid, bucket, instance_res, exhausted, input ready);
  modport sink   (input valid, bucket, instance_res, exhausted, output ready);
endinterface

// File: src/pba_first_free.sv
`timescale 1ns / 1ps

module pba_first_free
  import pba_pkg::*;
#(
  parameter int INSTANCES = INSTANCES_DEF
) (
  input  logic [INSTANCES-1:0] mask_i,
  output logic                 found_o,
  output logic [INST_W-1:0]    inst_o,
  output logic [INSTANCES-1:0] mask_o
);

  logic [INSTANCES-1:0] free;
  logic [INSTANCES-1:0] lowest;

  assign free    = ~mask_i;
  assign lowest  = free & (~free + INSTANCES'(1));
  assign found_o = |free;
  assign mask_o  = mask_i | lowest;

  // scan from the top so the lowest free bit wins
  always_comb begin
    inst_o = '0;
    for (int k = INSTANCES - 1; k >= 0; k--) begin
      if (free[k]) begin
        inst_o = INST_W'(k);
      end
    end
  end

endmodule

// File: src/probed_bitmap_id_allocator.sv
`timescale 1ns / 1ps

// Hands out unique (bucket, instance) pairs for the current command. The used
// masks live in one synchronous memory with a registered read; each entry
// carries an epoch tag, so clearing all masks (new command or reset request)
// is a single epoch increment. An allocation accepted in S_IDLE first, when
// BUCKETS is below 4096, reduces the start bucket modulo BUCKETS in S_REDUCE
// over red_steps(BUCKETS) steps, then reads a bucket in S_READ, checks it in
// S_CHECK (each further bucket probed repeats S_CHECK) and loads its result
// into the output register in S_EMIT; a reset request goes straight to S_EMIT.
// A new request is accepted only back in S_IDLE. After reset, and on every
// 256th clear when the epoch tag wraps, a clearing pass writes all BUCKETS
// entries, one per cycle, before work goes on. A result waiting in the output
// register does not block acceptance, but the next result waits in S_EMIT.
module probed_bitmap_id_allocator
  import pba_pkg::*;
#(
  parameter int BUCKETS   = BUCKETS_DEF,
  parameter int INSTANCES = INSTANCES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pba_in_if.sink    in_i,
  pba_out_if.source out_o
);

  localparam int BW        = $clog2(BUCKETS);
  localparam int RW        = (BW > BUCKET_W) ? BW : BUCKET_W;
  localparam int RED_STEPS = red_steps(BUCKETS);
  localparam int ENTRY_W   = EPOCH_W + INSTANCES;

  typedef enum logic [5:0] {
    S_SWEEP  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_REDUCE = 6'b000100,
    S_READ   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  state_e               ret_q, ret_d;
  logic [BW-1:0]        sweep_q, sweep_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic                 cmd_valid_q, cmd_valid_d;
  logic [RW-1:0]        pos_q, pos_d;
  logic [RED_CNT_W-1:0] red_k_q, red_k_d;
  logic [BW-1:0]        cnt_q, cnt_d;
  logic [BUCKET_W-1:0]  res_bucket_q, res_bucket_d;
  logic [INST_W-1:0]    res_inst_q, res_inst_d;
  logic                 res_exh_q, res_exh_d;
  logic                 out_valid_q, out_valid_d;
  logic [BUCKET_W-1:0]  out_bucket_q, out_bucket_d;
  logic [INST_W-1:0]    out_inst_q, out_inst_d;
  logic                 out_exh_q, out_exh_d;

  logic [ENTRY_W-1:0]   mask_mem [BUCKETS];
  logic [ENTRY_W-1:0]   rdata_q;
  logic                 rd_en, wr_en;
  logic [BW-1:0]        rd_addr, wr_addr;
  logic [ENTRY_W-1:0]   wdata;

  logic [BW-1:0]        idx, next_idx;
  logic [INSTANCES-1:0] eff_mask, new_mask;
  logic                 ff_found;
  logic [INST_W-1:0]    ff_inst;
  logic [RW:0]          thr;
  logic                 clr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mask_mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mask_mem[rd_addr];
    end
  end

  assign idx      = pos_q[BW-1:0];
  assign next_idx = (idx == BW'(BUCKETS - 1)) ? '0 : idx + BW'(1);
  // an entry tagged with an older epoch reads as empty
  assign eff_mask = (rdata_q[ENTRY_W-1 -: EPOCH_W] == epoch_q) ?
                    rdata_q[INSTANCES-1:0] : '0;
  assign thr      = (RW + 1)'(BUCKETS) << red_k_q;
  assign clr      = in_i.action || !cmd_valid_q || (in_i.command != cmd_q);

  pba_first_free #(
    .INSTANCES(INSTANCES)
  ) u_first_free (
    .mask_i (eff_mask),
    .found_o(ff_found),
    .inst_o (ff_inst),
    .mask_o (new_mask)
  );

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.bucket       = out_bucket_q;
  assign out_o.instance_res = out_inst_q;
  assign out_o.exhausted    = out_exh_q;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    sweep_d      = sweep_q;
    epoch_d      = epoch_q;
    cmd_d        = cmd_q;
    cmd_valid_d  = cmd_valid_q;
    pos_d        = pos_q;
    red_k_d      = red_k_q;
    cnt_d        = cnt_q;
    res_bucket_d = res_bucket_q;
    res_inst_d   = res_inst_q;
    res_exh_d    = res_exh_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_bucket_d = out_bucket_q;
    out_inst_d   = out_inst_q;
    out_exh_d    = out_exh_q;
    rd_en        = 1'b0;
    rd_addr      = idx;
    wr_en        = 1'b0;
    wr_addr      = idx;
    wdata        = {epoch_q, new_mask};

    case (state_q)
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        wdata   = '0;
        if (sweep_q == BW'(BUCKETS - 1)) begin
          state_d = ret_q;
        end else begin
          sweep_d = sweep_q + BW'(1);
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          pos_d        = RW'(in_i.start_bucket);
          red_k_d      = RED_CNT_W'(RED_STEPS - 1);
          res_bucket_d = '0;
          res_inst_d   = '0;
          res_exh_d    = 1'b0;
          if (in_i.action) begin
            cmd_d       = '0;
            cmd_valid_d = 1'b0;
            state_d     = S_EMIT;
          end else begin
            cmd_d       = in_i.command;
            cmd_valid_d = 1'b1;
            state_d     = (RED_STEPS > 0) ? S_REDUCE : S_READ;
          end
          if (clr) begin
            if (epoch_q == '1) begin
              // tag space used up: wipe the memory and restart the epoch
              epoch_d = '0;
              sweep_d = '0;
              ret_d   = state_d;
              state_d = S_SWEEP;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end
        end
      end
      S_REDUCE: begin
        if ({1'b0, pos_q} >= thr) begin
          pos_d = pos_q - thr[RW-1:0];
        end
        if (red_k_q == '0) begin
          state_d = S_READ;
        end else begin
          red_k_d = red_k_q - RED_CNT_W'(1);
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        cnt_d   = '0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (ff_found) begin
          wr_en        = 1'b1;
          res_bucket_d = BUCKET_W'(idx);
          res_inst_d   = ff_inst;
          res_exh_d    = 1'b0;
          state_d      = S_EMIT;
        end else if (cnt_q == BW'(BUCKETS - 1)) begin
          res_bucket_d = '0;
          res_inst_d   = '0;
          res_exh_d    = 1'b1;
          state_d      = S_EMIT;
        end else begin
          // bucket full: probe the next one, wrapping at the end
          rd_en   = 1'b1;
          rd_addr = next_idx;
          pos_d   = RW'(next_idx);
          cnt_d   = cnt_q + BW'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_bucket_d = res_bucket_q;
          out_inst_d   = res_inst_q;
          out_exh_d    = res_exh_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      ret_q       <= S_IDLE;
      sweep_q     <= '0;
      epoch_q     <= '0;
      cmd_q       <= '0;
      cmd_valid_q <= 1'b0;
      red_k_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      sweep_q     <= sweep_d;
      epoch_q     <= epoch_d;
      cmd_q       <= cmd_d;
      cmd_valid_q <= cmd_valid_d;
      red_k_q     <= red_k_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    res_bucket_q <= res_bucket_d;
    res_inst_q   <= res_inst_d;
    res_exh_q    <= res_exh_d;
    out_bucket_q <= out_bucket_d;
    out_inst_q   <= out_inst_d;
    out_exh_q    <= out_exh_d;
  end

endmodule

// File: tb/pba_tb_pkg.sv
`timescale 1ns / 1ps

package pba_tb_pkg;

  typedef enum bit {
    ACT_ALLOC = 1'b0,
    ACT_FLUSH = 1'b1
  } req_action_e;

endpackage

// File: tb/pba_alloc_checker.sv
`timescale 1ns / 1ps

module pba_alloc_checker
  import pba_pkg::*;
  import pba_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pba_in_if    req_mon,
  pba_out_if   rsp_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   alloc_cnt_o,
  output int   flush_cnt_o,
  output int   exhaust_cnt_o,
  output int   max_probe_o
);

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [INST_W-1:0]   inst;
    logic                exhausted;
  } id_pair_t;

  id_pair_t                 pair_q[$];
  logic [INSTANCES_DEF-1:0] used_tbl [BUCKETS_DEF];
  logic [CMD_W-1:0]         cur_cmd;
  bit                       cmd_live;

  function automatic void wipe_masks();
    foreach (used_tbl[b]) used_tbl[b] = '0;
  endfunction

  // Advance the allocator state by one request and return the pair it hands out.
  function automatic id_pair_t take_id(req_action_e act, logic [CMD_W-1:0] cmd,
                                       logic [BUCKET_W-1:0] sb);
    id_pair_t                 res;
    logic [BUCKET_W-1:0]      b;
    logic [INSTANCES_DEF-1:0] m;
    res = '0;
    if (act == ACT_FLUSH) begin
      wipe_masks();
      cur_cmd     = '0;
      cmd_live    = 1'b0;
      flush_cnt_o = flush_cnt_o + 1;
      return res;
    end
    if (!cmd_live || cmd != cur_cmd) begin
      wipe_masks();
      cur_cmd  = cmd;
      cmd_live = 1'b1;
    end
    alloc_cnt_o = alloc_cnt_o + 1;
    for (int p = 0; p < BUCKETS_DEF; p++) begin
      b = BUCKET_W'((int'(sb) + p) % BUCKETS_DEF);
      m = used_tbl[b];
      if (&m) continue;
      for (int i = 0; i < INSTANCES_DEF; i++) begin
        if (!m[i]) begin
          used_tbl[b][i] = 1'b1;
          res.bucket     = b;
          res.inst       = INST_W'(i);
          if (p > max_probe_o) max_probe_o = p;
          return res;
        end
      end
    end
    // every pair taken: masks stay as they are
    res.exhausted = 1'b1;
    exhaust_cnt_o = exhaust_cnt_o + 1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    id_pair_t exp_pair;
    if (!rst_ni) begin
      pair_q.delete();
      wipe_masks();
      cur_cmd       = '0;
      cmd_live      = 1'b0;
      fail_cnt_o    = 0;
      pending_o     = 0;
      alloc_cnt_o   = 0;
      flush_cnt_o   = 0;
      exhaust_cnt_o = 0;
      max_probe_o   = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pair_q.size() == 0) begin
          $error("result with no request pending: bucket %0d instance %0d exhausted %0d",
                 rsp_mon.bucket, rsp_mon.instance_res, rsp_mon.exhausted);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          exp_pair = pair_q.pop_front();
          if (rsp_mon.bucket !== exp_pair.bucket) begin
            $error("bucket: expected %0d, actual %0d", exp_pair.bucket, rsp_mon.bucket);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (rsp_mon.instance_res !== exp_pair.inst) begin
            $error("instance_res: expected %0d, actual %0d", exp_pair.inst,
                   rsp_mon.instance_res);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (rsp_mon.exhausted !== exp_pair.exhausted) begin
            $error("exhausted: expected %0d, actual %0d", exp_pair.exhausted,
                   rsp_mon.exhausted);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        pair_q.push_back(take_id(req_action_e'(req_mon.action), req_mon.command,
                                 req_mon.start_bucket));
      end
      pending_o = pair_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pba_pkg::*;
  import pba_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_AT        = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int TAIL_CYCLES    = 50;
  localparam int FILL_BUCKETS   = 32;
  localparam int FILL_PAIRS     = FILL_BUCKETS * INSTANCES_DEF;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   rsp_seen;
  int   quiet_cycles;

  int fail_cnt, pending, alloc_cnt, flush_cnt, exhaust_cnt, max_probe;

  pba_in_if  req_ch ();
  pba_out_if rsp_ch ();

  probed_bitmap_id_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  pba_alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .alloc_cnt_o   (alloc_cnt),
    .flush_cnt_o   (flush_cnt),
    .exhaust_cnt_o (exhaust_cnt),
    .max_probe_o   (max_probe)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold valid across back-to-back transactions; drop it only for a real gap.
  task automatic send_req(req_action_e act, logic [CMD_W-1:0] cmd,
                          logic [BUCKET_W-1:0] sb);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.command      <= cmd;
    req_ch.start_bucket <= sb;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the block.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rsp_seen == HOLD_AT) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = idle_on ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      rsp_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [CMD_W-1:0]    cmd;
    logic [CMD_W-1:0]    prev_cmd;
    logic [BUCKET_W-1:0] base;
    int                  sent;
    int                  burst;
    bit                  clustered;

    rst_ni              <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_ALLOC;
    req_ch.command      <= '0;
    req_ch.start_bucket <= '0;
    rsp_ch.ready        <= 1'b0;
    idle_on             = 1'b1;
    rsp_seen            = 0;
    quiet_cycles        = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: command zero right after reset, field extremes, wrap at the top bucket.
    send_req(ACT_ALLOC, '0, '0);
    send_req(ACT_ALLOC, '0, '0);
    send_req(ACT_ALLOC, '0, '1);
    send_req(ACT_ALLOC, '1, '1);
    send_req(ACT_ALLOC, '1, '1);
    send_req(ACT_FLUSH, '1, '1);
    send_req(ACT_ALLOC, '1, '1);
    repeat (INSTANCES_DEF - 1) send_req(ACT_ALLOC, '1, '1);
    send_req(ACT_ALLOC, '1, '1);
    send_req(ACT_FLUSH, '0, '0);

    // Fill a run of buckets for one command, then probe into it to walk past the run.
    idle_on = 1'b0;
    cmd     = CMD_W'($urandom());
    for (int k = 0; k < FILL_PAIRS; k++) begin
      send_req(ACT_ALLOC, cmd, BUCKET_W'(k / INSTANCES_DEF));
    end
    send_req(ACT_ALLOC, cmd, '0);
    send_req(ACT_ALLOC, cmd, BUCKET_W'($urandom_range(0, FILL_BUCKETS - 1)));
    send_req(ACT_FLUSH, CMD_W'($urandom()), BUCKET_W'($urandom()));

    // Random: bursts per command, some clustered on a few buckets to force probing.
    sent     = 0;
    prev_cmd = cmd;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 19) == 0) begin
        send_req(ACT_FLUSH, CMD_W'($urandom()), BUCKET_W'($urandom()));
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1:    cmd = prev_cmd;
        2:       cmd = CMD_W'($urandom_range(0, 3));
        default: cmd = CMD_W'($urandom());
      endcase
      prev_cmd  = cmd;
      burst     = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      clustered = $urandom_range(0, 1);
      base      = BUCKET_W'($urandom());
      for (int j = 0; j < burst; j++) begin
        send_req(ACT_ALLOC, cmd,
                 clustered ? base + BUCKET_W'($urandom_range(0, 3)) : BUCKET_W'($urandom()));
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d allocations (%0d exhausted) and %0d reset requests;",
             alloc_cnt, exhaust_cnt, flush_cnt);
    $display("deepest probe walked %0d buckets past the start.", max_probe);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/pba_pkg.sv
src/pba_in_if.sv
src/pba_out_if.sv
src/pba_first_free.sv
src/probed_bitmap_id_allocator.sv
tb/pba_tb_pkg.sv
tb/pba_alloc_checker.sv
tb/tb_top.sv
